### design/cpmm_pkg.sv
// cpmm_pkg: shared types and constants for the cascaded PID motor mixer.
// No dependencies.
`timescale 1ns / 1ps
package cpmm_pkg;
   localparam int GAIN_W = 24;
   localparam int NUM_GAINS = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KI = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KD = 3'd5;

   // 2^61-1 product/term bound
   localparam logic signed [63:0] ACC_LIM = 64'sh1FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
      logic signed [15:0] yaw_target;
      logic signed [15:0] pitch_target;
      logic signed [15:0] roll_target;
      logic signed [15:0] yaw_rate;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] roll_rate;
      logic [15:0]        elapsed_ms;
      logic [7:0]         throttle;
   } req_type;

   typedef struct packed {
      logic [7:0] motor_front;
      logic [7:0] motor_back;
      logic [7:0] motor_left;
      logic [7:0] motor_right;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gains_type;

   // per-lane control from the sequencer
   typedef struct packed {
      logic start;   // begin a PID evaluation
      logic outer;   // outer loop (divisor 4*dt+1, rounded setpoint)
   } lane_ctl_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) return 16'sh7FFF;
      if (v < -18'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [63:0] clamp_acc(input logic signed [65:0] v);
      if (v > 66'(ACC_LIM)) return ACC_LIM;
      if (v < -66'(ACC_LIM)) return -ACC_LIM;
      return v[63:0];
   endfunction
endpackage

### design/cpmm_lane.sv
// cpmm_lane: one axis PID lane with its own state, a shared multiply sequence
// and a bit-serial divider for the derivative term. Depends on cpmm_pkg.
`timescale 1ns / 1ps
module cpmm_lane import cpmm_pkg::*; #(
   parameter int SUM_WIDTH = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctl_type        ctl,
   input  gains_type           outer_g,
   input  gains_type           inner_g,
   input  logic signed [15:0]  angle,
   input  logic signed [15:0]  target,
   input  logic signed [15:0]  rate,
   input  logic [15:0]         elapsed_ms,
   output logic                done,
   output logic signed [63:0]  cmd
);
   localparam logic signed [SUM_WIDTH-1:0] SUM_HI = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_LO = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic signed [SUM_WIDTH-1:0] asum_ff, asum_in, rsum_ff, rsum_in;
   logic signed [15:0] aprev_ff, aprev_in, rprev_ff, rprev_in, rsp_ff, rsp_in;
   logic outer_ff, outer_in;
   logic signed [15:0] e_ff, e_in;
   logic signed [16:0] de_ff, de_in;
   logic signed [SUM_WIDTH-1:0] s_ff, s_in;
   logic signed [63:0] pp_ff, pp_in, pi_ff, pi_in, pd_ff, pd_in;
   logic [1:0] mstep_ff, mstep_in;
   logic [6:0] dcnt_ff, dcnt_in;
   logic [61:0] quo_ff, quo_in;
   logic [18:0] rem_ff, rem_in;
   logic signed [63:0] cmd_ff, cmd_in;
   logic done_ff, done_in;

   gains_type g;
   logic signed [15:0] err;
   logic signed [SUM_WIDTH-1:0] sbase, snew;
   logic signed [SUM_WIDTH:0] sadd;
   logic [GAIN_W-1:0] mg;
   logic signed [SUM_WIDTH-1:0] mv;
   logic mneg;
   logic [SUM_WIDTH-1:0] mmag;
   logic [SUM_WIDTH+GAIN_W-1:0] mprod;
   logic signed [63:0] mres;
   logic [18:0] divisor, rtry;
   logic [19:0] rsh;
   logic [61:0] dmag;
   logic signed [65:0] tsum;
   logic signed [63:0] tcl, rnd;
   logic signed [64:0] radd;
   logic signed [36:0] rsh28;

   assign g = outer_ff ? outer_g : inner_g;
   assign divisor = outer_ff ? {1'b0, elapsed_ms, 2'b00} + 19'd1 : {3'b0, elapsed_ms} + 19'd1;

   always_comb begin
      logic signed [17:0] d;
      if (ctl.outer) d = 18'(target) - 18'(angle);
      else           d = 18'(rsp_ff) - 18'(rate);
      err = sat16(d);
   end
   assign sbase = ctl.outer ? asum_ff : (outer_ff ? '0 : rsum_ff);
   assign sadd = (SUM_WIDTH+1)'(sbase) + (SUM_WIDTH+1)'(err);
   assign snew = (sadd > (SUM_WIDTH+1)'(SUM_HI)) ? SUM_HI :
                 (sadd < (SUM_WIDTH+1)'(SUM_LO)) ? SUM_LO : sadd[SUM_WIDTH-1:0];

   // one gain product per cycle: kp*e, ki*sum, kd*de
   always_comb begin
      unique case (mstep_ff)
         2'd0:    begin mg = g.kp; mv = SUM_WIDTH'(e_ff); end
         2'd1:    begin mg = g.ki; mv = s_ff; end
         default: begin mg = g.kd; mv = SUM_WIDTH'(de_ff); end
      endcase
      mneg = mv[SUM_WIDTH-1];
      mmag = mneg ? SUM_WIDTH'(-mv) : mv;
      mprod = (SUM_WIDTH+GAIN_W)'(mmag) * (SUM_WIDTH+GAIN_W)'(mg);
      if ((SUM_WIDTH+GAIN_W)'(mprod) > (SUM_WIDTH+GAIN_W)'(ACC_LIM))
         mres = mneg ? -ACC_LIM : ACC_LIM;
      else mres = mneg ? -64'(mprod) : 64'(mprod);
   end

   assign dmag = pd_ff[63] ? 62'(-pd_ff) : 62'(pd_ff);
   assign rsh = {rem_ff, dmag[dcnt_ff[5:0]]};
   assign rtry = 19'(rsh - 20'(divisor));

   always_comb begin
      logic signed [63:0] dq;
      dq = pd_ff[63] ? -64'(quo_ff) : 64'(quo_ff);
      tsum = 66'(pp_ff) + 66'(pi_ff) + 66'(dq);
   end
   assign tcl = clamp_acc(tsum);
   assign radd = 65'(tcl) + 65'sd134217728;
   assign rsh28 = 37'(radd >>> 28);
   assign rnd = (rsh28 > 37'sd32767) ? 64'sd32767 :
                (rsh28 < -37'sd32768) ? -64'sd32768 : 64'(rsh28);

   always_comb begin
      state_in = state_ff; asum_in = asum_ff; rsum_in = rsum_ff;
      aprev_in = aprev_ff; rprev_in = rprev_ff; rsp_in = rsp_ff;
      outer_in = outer_ff; e_in = e_ff; de_in = de_ff; s_in = s_ff;
      pp_in = pp_ff; pi_in = pi_ff; pd_in = pd_ff; mstep_in = mstep_ff;
      dcnt_in = dcnt_ff; quo_in = quo_ff; rem_in = rem_ff;
      cmd_in = cmd_ff; done_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (ctl.start) begin
            outer_in = ctl.outer;
            e_in = err; s_in = snew; mstep_in = 2'd0;
            if (ctl.outer) begin
               asum_in = snew; de_in = 17'(err) - 17'(aprev_ff); aprev_in = err;
               rsum_in = '0; rprev_in = '0;
            end else begin
               rsum_in = snew; de_in = 17'(err) - 17'(rprev_ff); rprev_in = err;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            unique case (mstep_ff)
               2'd0: pp_in = mres;
               2'd1: pi_in = mres;
               default: pd_in = mres;
            endcase
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd2) begin
               state_in = S_DIV; dcnt_in = 7'd61; quo_in = '0; rem_in = '0;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            if (!rtry[18] && rsh >= 20'(divisor)) begin
               rem_in = rtry; quo_in = {quo_ff[60:0], 1'b1};
            end else begin
               rem_in = rsh[18:0]; quo_in = {quo_ff[60:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 7'd1;
            if (dcnt_ff == 7'd0) state_in = S_SUM;
         end
         S_SUM: begin
            if (outer_ff) begin
               rsp_in = rnd[15:0]; state_in = S_IDLE; done_in = 1'b1;
            end else begin
               cmd_in = tcl; state_in = S_IDLE; done_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; asum_ff <= '0; rsum_ff <= '0;
         aprev_ff <= '0; rprev_ff <= '0; rsp_ff <= '0; outer_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in; asum_ff <= asum_in; rsum_ff <= rsum_in;
         aprev_ff <= aprev_in; rprev_ff <= rprev_in; rsp_ff <= rsp_in;
         outer_ff <= outer_in; done_ff <= done_in;
      end
      e_ff <= e_in; de_ff <= de_in; s_ff <= s_in; pp_ff <= pp_in; pi_ff <= pi_in;
      pd_ff <= pd_in; mstep_ff <= mstep_in; dcnt_ff <= dcnt_in; quo_ff <= quo_in;
      rem_ff <= rem_in; cmd_ff <= cmd_in;
   end

   assign done = done_ff;
   assign cmd = cmd_ff;
endmodule

### design/cpmm_mixer.sv
// cpmm_mixer: merges the three axis commands with throttle into four
// saturated motor drives. Depends on cpmm_pkg.
`timescale 1ns / 1ps
module cpmm_mixer import cpmm_pkg::*; (
   input  logic signed [63:0] yaw_cmd,
   input  logic signed [63:0] pitch_cmd,
   input  logic signed [63:0] roll_cmd,
   input  logic [7:0]         throttle,
   output rsp_type            motors
);
   logic signed [65:0] thr;

   function automatic logic [7:0] drive(input logic signed [65:0] q16);
      logic signed [49:0] m;
      m = 50'(q16 >>> 16);
      if (m < 0) return 8'd0;
      if (m > 50'sd255) return 8'd255;
      return m[7:0];
   endfunction

   assign thr = 66'($signed({1'b0, throttle, 16'd0}));
   assign motors.motor_front = drive(thr + 66'(pitch_cmd) - 66'(yaw_cmd));
   assign motors.motor_back  = drive(thr - 66'(pitch_cmd) - 66'(yaw_cmd));
   assign motors.motor_left  = drive(thr + 66'(roll_cmd) + 66'(yaw_cmd));
   assign motors.motor_right = drive(thr - 66'(roll_cmd) + 66'(yaw_cmd));
endmodule

### design/cascaded_pid_motor_mixer.sv
// cascaded_pid_motor_mixer: top level; gain registers, tick sequencer, three
// axis lanes and the motor mixer. Depends on cpmm_pkg, cpmm_lane, cpmm_mixer.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      req_type (angles, targets, rates, dt, throttle)
//   rsp      out  valid/ready      rsp_type (four motor drives)
//   csr      in   write enable     index + 24-bit gain
//
// rsp_valid rises once a req beat has run through the lanes and the mix step;
// outer-loop ticks (one in OUTER_DIVIDE) run an outer pass before the inner one. A
// lane pass is start, three gain products, a bit-serial division of the derivative
// term, the sum and the done handoff. Lanes run in parallel. One tick is in flight
// at a time and req_ready returns the cycle after the rsp register loads; a
// stalled rsp beat holds the next tick in its mix step. Reset is synchronous.
`timescale 1ns / 1ps
module cascaded_pid_motor_mixer import cpmm_pkg::*; #(
   parameter int OUTER_DIVIDE = 4,
   parameter int SUM_WIDTH = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata
);
   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_OUTER = 2'd1;
   localparam logic [1:0] T_INNER = 2'd2;
   localparam logic [1:0] T_MIX   = 2'd3;

   logic [GAIN_W-1:0] gain_ff [NUM_GAINS];
   logic [1:0] st_ff, st_in;
   logic [2:0] cnt_ff, cnt_in;
   req_type req_ff;
   logic busy_started_ff;
   rsp_type rsp_ff, mix;
   logic rsp_valid_ff, rsp_valid_in;
   lane_ctl_type ctl;
   gains_type og, ig;
   logic [2:0] done;
   logic lanes_done;
   logic mix_load;
   logic signed [63:0] cmd [3];

   assign og = '{kp: gain_ff[REG_OUTER_KP], ki: gain_ff[REG_OUTER_KI],
                 kd: gain_ff[REG_OUTER_KD]};
   assign ig = '{kp: gain_ff[REG_INNER_KP], ki: gain_ff[REG_INNER_KI],
                 kd: gain_ff[REG_INNER_KD]};

   assign req_ready = (st_ff == T_IDLE);
   assign lanes_done = &done;
   // result register frees up when empty or its beat leaves this cycle
   assign mix_load = (st_ff == T_MIX) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; rsp_valid_in = rsp_valid_ff;
      ctl = '{start: 1'b0, outer: 1'b0};
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (st_ff)
         T_IDLE: ;
         T_OUTER: if (!busy_started_ff) ctl = '{start: 1'b1, outer: 1'b1};
                  else if (lanes_done) st_in = T_INNER;
         T_INNER: if (!busy_started_ff) ctl = '{start: 1'b1, outer: 1'b0};
                  else if (lanes_done) st_in = T_MIX;
         default: if (mix_load) begin st_in = T_IDLE; rsp_valid_in = 1'b1; end
      endcase
      if (req_valid && req_ready) begin
         if (cnt_ff == 3'd0) begin
            st_in = T_OUTER; cnt_in = 3'(OUTER_DIVIDE - 1);
         end else begin
            st_in = T_INNER; cnt_in = cnt_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_IDLE; cnt_ff <= '0; rsp_valid_ff <= 1'b0; busy_started_ff <= 1'b0;
         gain_ff[REG_OUTER_KP] <= 24'd655360; gain_ff[REG_OUTER_KI] <= '0;
         gain_ff[REG_OUTER_KD] <= '0;
         gain_ff[REG_INNER_KP] <= 24'd98304; gain_ff[REG_INNER_KI] <= 24'd7;
         gain_ff[REG_INNER_KD] <= 24'd65536;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; rsp_valid_ff <= rsp_valid_in;
         busy_started_ff <= (st_in == st_ff) && !(req_valid && req_ready) &&
                            (busy_started_ff || ctl.start);
         if (csr_we && csr_index < CSR_IDX_W'(NUM_GAINS))
            gain_ff[csr_index] <= csr_wdata;
      end
      if (req_valid && req_ready) req_ff <= req_data;
      if (mix_load) rsp_ff <= mix;
   end

   cpmm_lane #(.SUM_WIDTH(SUM_WIDTH)) u_yaw (
      .clock, .reset, .ctl, .outer_g(og), .inner_g(ig),
      .angle(req_ff.yaw_angle), .target(req_ff.yaw_target), .rate(req_ff.yaw_rate),
      .elapsed_ms(req_ff.elapsed_ms), .done(done[0]), .cmd(cmd[0]));
   cpmm_lane #(.SUM_WIDTH(SUM_WIDTH)) u_pitch (
      .clock, .reset, .ctl, .outer_g(og), .inner_g(ig),
      .angle(req_ff.pitch_angle), .target(req_ff.pitch_target),
      .rate(req_ff.pitch_rate),
      .elapsed_ms(req_ff.elapsed_ms), .done(done[1]), .cmd(cmd[1]));
   cpmm_lane #(.SUM_WIDTH(SUM_WIDTH)) u_roll (
      .clock, .reset, .ctl, .outer_g(og), .inner_g(ig),
      .angle(req_ff.roll_angle), .target(req_ff.roll_target), .rate(req_ff.roll_rate),
      .elapsed_ms(req_ff.elapsed_ms), .done(done[2]), .cmd(cmd[2]));

   cpmm_mixer u_mix (
      .yaw_cmd(cmd[0]), .pitch_cmd(cmd[1]), .roll_cmd(cmd[2]),
      .throttle(req_ff.throttle), .motors(mix));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

### bench/tb_checker.sv
// tb_checker: watches the req, rsp and csr ports of the motor mixer, predicts
// each tick's motor drives and compares them beat by beat. Depends on cpmm_pkg.
`timescale 1ns / 1ps
module tb_checker import cpmm_pkg::*; #(
   parameter int OUTER_DIVIDE = 4,
   parameter int SUM_WIDTH = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   localparam longint TERM_LIM = 64'sh1FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   logic [GAIN_W-1:0] gain_reg[NUM_GAINS];
   int     tick_count;
   longint ang_sum[3], ang_prev[3], rate_sp[3], rate_sum[3], rate_prev[3];
   rsp_type motor_q[$];
   int     fails = 0;

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint clip_term(longint v);
      if (v > TERM_LIM) return TERM_LIM;
      if (v < -TERM_LIM) return -TERM_LIM;
      return v;
   endfunction

   function automatic longint acc_add(longint s, longint e);
      if (e > 0 && s > SUM_HI - e) return SUM_HI;
      if (e < 0 && s < SUM_LO - e) return SUM_LO;
      return s + e;
   endfunction

   function automatic longint mul_gain(logic [GAIN_W-1:0] g, longint v);
      longint unsigned m;
      longint unsigned gu;
      longint p;
      gu = longint'(g);
      m = (v < 0) ? longint'(-(v + 1)) + 1 : v;
      if (gu == 0 || m == 0) return 0;
      if (m > longint'(TERM_LIM) / gu) return (v < 0) ? -TERM_LIM : TERM_LIM;
      p = m * gu;
      return (v < 0) ? -p : p;
   endfunction

   function automatic longint pid_eval(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                       logic [GAIN_W-1:0] kd, longint e, longint s,
                                       longint de, longint div);
      return clip_term(mul_gain(kp, e) + mul_gain(ki, s) + mul_gain(kd, de) / div);
   endfunction

   function automatic logic [7:0] motor_sat(longint q16);
      longint m;
      m = q16 >>> 16;
      if (m < 0) return 8'd0;
      if (m > 255) return 8'd255;
      return m[7:0];
   endfunction

   task automatic predict_tick(req_type t);
      longint ang[3], tgt[3], rate[3], cmd[3];
      longint dt, thr, e, r;
      rsp_type m;
      ang[0] = t.yaw_angle;  ang[1] = t.pitch_angle;  ang[2] = t.roll_angle;
      tgt[0] = t.yaw_target; tgt[1] = t.pitch_target; tgt[2] = t.roll_target;
      rate[0] = t.yaw_rate;  rate[1] = t.pitch_rate;  rate[2] = t.roll_rate;
      dt = longint'(t.elapsed_ms);
      thr = longint'(t.throttle) * 65536;
      if (tick_count == 0) begin
         tick_count = OUTER_DIVIDE;
         for (int i = 0; i < 3; i++) begin
            e = clip16(tgt[i] - ang[i]);
            ang_sum[i] = acc_add(ang_sum[i], e);
            r = pid_eval(gain_reg[REG_OUTER_KP], gain_reg[REG_OUTER_KI],
                         gain_reg[REG_OUTER_KD], e, ang_sum[i], e - ang_prev[i],
                         4 * dt + 1);
            ang_prev[i] = e;
            rate_sp[i] = clip16((r + (64'sd1 <<< 27)) >>> 28);
            rate_sum[i] = 0;
            rate_prev[i] = 0;
         end
      end
      for (int i = 0; i < 3; i++) begin
         e = clip16(rate_sp[i] - rate[i]);
         rate_sum[i] = acc_add(rate_sum[i], e);
         cmd[i] = pid_eval(gain_reg[REG_INNER_KP], gain_reg[REG_INNER_KI],
                           gain_reg[REG_INNER_KD], e, rate_sum[i], e - rate_prev[i],
                           dt + 1);
         rate_prev[i] = e;
      end
      tick_count = (tick_count - 1) & 7;
      m.motor_front = motor_sat(thr + cmd[1] - cmd[0]);
      m.motor_back  = motor_sat(thr - cmd[1] - cmd[0]);
      m.motor_left  = motor_sat(thr + cmd[2] + cmd[0]);
      m.motor_right = motor_sat(thr - cmd[2] + cmd[0]);
      motor_q.push_back(m);
   endtask

   task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         fails++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         gain_reg[REG_OUTER_KP] = 24'd655360;
         gain_reg[REG_OUTER_KI] = 24'd0;
         gain_reg[REG_OUTER_KD] = 24'd0;
         gain_reg[REG_INNER_KP] = 24'd98304;
         gain_reg[REG_INNER_KI] = 24'd7;
         gain_reg[REG_INNER_KD] = 24'd65536;
         tick_count = 0;
         for (int i = 0; i < 3; i++) begin
            ang_sum[i] = 0; ang_prev[i] = 0; rate_sp[i] = 0;
            rate_sum[i] = 0; rate_prev[i] = 0;
         end
         motor_q.delete();
      end else begin
         if (csr_we && csr_index < NUM_GAINS) gain_reg[csr_index] = csr_wdata;
         if (req_valid && req_ready) predict_tick(req_data);
         if (rsp_valid && rsp_ready) begin
            if (motor_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected rsp beat, expected none, got %h", $time,
                        rsp_data);
            end else begin
               w = motor_q.pop_front();
               check_field("motor_front", w.motor_front, rsp_data.motor_front);
               check_field("motor_back", w.motor_back, rsp_data.motor_back);
               check_field("motor_left", w.motor_left, rsp_data.motor_left);
               check_field("motor_right", w.motor_right, rsp_data.motor_right);
            end
         end
      end
      pending <= motor_q.size();
      fail_count <= fails;
   end
endmodule

### bench/tb_top.sv
// tb_top: clock, reset and stimulus for cascaded_pid_motor_mixer; the checker
// module does prediction and comparison. Depends on cpmm_pkg and tb_checker.
`timescale 1ns / 1ps
module tb_top;
   import cpmm_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0] csr_wdata;
   int fail_count, pending, ticks_sent;
   bit idle_on;

   cascaded_pid_motor_mixer dut (.*);
   tb_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock)
      rsp_ready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;

   function automatic logic [15:0] pick16(bit small_range);
      if (small_range) return 16'($signed($urandom_range(4000)) - 2000);
      return 16'($urandom);
   endfunction

   function automatic req_type rand_tick();
      req_type t;
      bit sm;
      sm = $urandom_range(99) < 60;
      t.yaw_angle = pick16(sm);   t.pitch_angle = pick16(sm);
      t.roll_angle = pick16(sm);  t.yaw_target = pick16(sm);
      t.pitch_target = pick16(sm); t.roll_target = pick16(sm);
      t.yaw_rate = pick16(sm);    t.pitch_rate = pick16(sm);
      t.roll_rate = pick16(sm);
      case ($urandom_range(3))
         0: t.elapsed_ms = 16'($urandom);
         1: t.elapsed_ms = 16'd0;
         default: t.elapsed_ms = 16'($urandom_range(20));
      endcase
      t.throttle = 8'($urandom);
      return t;
   endfunction

   task automatic send_tick(req_type t);
      while (idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      // ready only moves at the rising edge; look at it mid-cycle
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      ticks_sent++;
   endtask

   // drain: sender holds off until all expected beats are back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic load_gains(logic [GAIN_W-1:0] okp, logic [GAIN_W-1:0] oki,
                             logic [GAIN_W-1:0] okd, logic [GAIN_W-1:0] ikp,
                             logic [GAIN_W-1:0] iki, logic [GAIN_W-1:0] ikd);
      logic [GAIN_W-1:0] v[NUM_GAINS];
      v[REG_OUTER_KP] = okp; v[REG_OUTER_KI] = oki; v[REG_OUTER_KD] = okd;
      v[REG_INNER_KP] = ikp; v[REG_INNER_KI] = iki; v[REG_INNER_KD] = ikd;
      for (int i = 0; i < NUM_GAINS; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i];
         @(posedge clock);
      end
      // out-of-range indexes must be dropped
      csr_index <= 3'd6;
      csr_wdata <= 24'hFFFFFF;
      @(posedge clock);
      csr_index <= 3'd7;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) idle_on = (i % 300 != 200);
         send_tick(rand_tick());
      end
   endtask

   initial begin
      req_type t;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      ticks_sent = 0;
      idle_on = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks at reset gains: saturating errors, dt extremes, throttle ends
      for (int k = 0; k < 20; k++) begin
         t = '0;
         case (k % 5)
            0: begin
               t.yaw_angle = -16'sd32768; t.pitch_angle = -16'sd32768;
               t.roll_angle = -16'sd32768; t.yaw_target = 16'sd32767;
               t.pitch_target = 16'sd32767; t.roll_target = 16'sd32767;
               t.yaw_rate = -16'sd32768; t.pitch_rate = 16'sd32767;
               t.roll_rate = -16'sd32768; t.throttle = 8'd255;
               t.elapsed_ms = 16'd0;
            end
            1: begin
               t.yaw_angle = 16'sd32767; t.pitch_angle = 16'sd32767;
               t.roll_angle = 16'sd32767; t.yaw_target = -16'sd32768;
               t.pitch_target = -16'sd32768; t.roll_target = -16'sd32768;
               t.yaw_rate = 16'sd32767; t.pitch_rate = -16'sd32768;
               t.roll_rate = 16'sd32767; t.elapsed_ms = 16'hFFFF;
            end
            2: begin
               t.throttle = 8'd128;
               t.elapsed_ms = 16'd1;
            end
            3: t = rand_tick();
            default: begin
               t = '1;
               t.throttle = 8'd0;
            end
         endcase
         send_tick(t);
      end
      random_run(200);
      drain();

      load_gains('1, '1, '1, '1, '1, '1);
      random_run(200);
      drain();

      load_gains('0, '0, '0, '0, '0, '0);
      random_run(150);
      drain();

      for (int p = 0; p < 4; p++) begin
         load_gains(24'($urandom), 24'($urandom_range(4096)), 24'($urandom),
                    24'($urandom_range(1 << 20)), 24'($urandom_range(256)),
                    24'($urandom));
         random_run(220);
         drain();
      end

      $display("Sent %0d ticks over seven gain settings, incl. all-max and all-zero.",
               ticks_sent);
      $display("Random stalls on both channels, with stall-free stretches.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
